// ----- sv/assert_macros.svh -----
// Assertion helpers used by the bound checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define RMST_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

`define RMST_NEVER(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) \
    else $error("forbidden condition seen");

`endif

// ----- sv/rmst_pkg.sv -----
package rmst_pkg;

  localparam int MAX_ROWS    = 32;
  localparam int MAX_COLS    = 32;
  localparam int LEVELS      = 6;
  localparam int VALUE_WIDTH = 16;

  localparam int POS_W  = 5;
  localparam int CFG_W  = 6;
  localparam int PW_W   = CFG_W + 1;
  localparam int LVL_W  = $clog2(LEVELS);
  localparam int LCNT_W = $clog2(LEVELS + 1);
  localparam int LIDX_W = $clog2(LEVELS * LEVELS);
  localparam int ADDR_W = LIDX_W + 2 * POS_W;
  localparam int DEPTH  = LEVELS * LEVELS * (1 << (2 * POS_W));

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_BUILD = 2'd1,
    KIND_QUERY = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD     = 2'd1,
    ST_UNBUILT = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_BUILD,
    OP_QUERY,
    OP_BAD
  } op_e;

  typedef enum logic {
    REG_ROWS = 1'b0,
    REG_COLS = 1'b1
  } reg_e;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_LVL,
    BK_RDA,
    BK_RDB,
    BK_WR,
    BK_Q0,
    BK_Q1,
    BK_Q2,
    BK_Q3,
    BK_QL
  } bk_state_e;

  typedef struct packed {
    logic [1:0]                    kind;
    logic [POS_W-1:0]              row_start;
    logic [POS_W-1:0]              col_start;
    logic [POS_W-1:0]              row_end;
    logic [POS_W-1:0]              col_end;
    logic signed [VALUE_WIDTH-1:0] cell_value;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] max_value;
    logic [1:0]                    status;
  } out_item_t;

  typedef struct packed {
    op_e                           op;
    logic [POS_W-1:0]              r0;
    logic [POS_W-1:0]              c0;
    logic [POS_W-1:0]              rb;
    logic [POS_W-1:0]              cb;
    logic [LVL_W-1:0]              t1;
    logic [LVL_W-1:0]              t2;
    logic signed [VALUE_WIDTH-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [CFG_W-1:0] rows;
    logic [CFG_W-1:0] cols;
    logic             wr;
  } cfg_t;

  function automatic logic [ADDR_W-1:0] tab_addr(logic [POS_W-1:0] r, logic [POS_W-1:0] c,
                                                 logic [LVL_W-1:0] i, logic [LVL_W-1:0] j);
    logic [LIDX_W-1:0] li;
    li = LIDX_W'(i) * LIDX_W'(LEVELS) + LIDX_W'(j);
    return {li, r, c};
  endfunction

  // leading-one detect, capped at the top level
  function automatic logic [LVL_W-1:0] floor_log2(logic [CFG_W-1:0] v);
    int t;
    t = 0;
    for (int b = 0; b < CFG_W; b++) begin
      if (v[b]) t = b;
    end
    if (t > LEVELS - 1) t = LEVELS - 1;
    return LVL_W'(t);
  endfunction

  function automatic logic signed [VALUE_WIDTH-1:0] vmax(logic signed [VALUE_WIDTH-1:0] a,
                                                         logic signed [VALUE_WIDTH-1:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic [CFG_W-1:0] sat_cfg(logic [CFG_W-1:0] v, logic [CFG_W-1:0] maxv);
    logic [CFG_W-1:0] r;
    r = v;
    if (v == '0) r = CFG_W'(1);
    else if (v > maxv) r = maxv;
    return r;
  endfunction

endpackage

// ----- sv/rmst_front.sv -----
module rmst_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  rmst_pkg::in_item_t       in_data_i,
  input  logic [rmst_pkg::CFG_W-1:0] rows_i,
  input  logic [rmst_pkg::CFG_W-1:0] cols_i,
  output logic                     cmd_valid_o,
  input  logic                     cmd_ready_i,
  output rmst_pkg::cmd_t           cmd_o
);

  logic           v_q, v_d;
  rmst_pkg::cmd_t cmd_q, cmd_d;
  logic [rmst_pkg::CFG_W-1:0] r0w, c0w, r1w, c1w, hgt, wid;
  logic           take;

  assign in_ready_o  = !v_q || cmd_ready_i;
  assign cmd_valid_o = v_q;
  assign cmd_o       = cmd_q;
  assign take        = in_valid_i && in_ready_o;

  assign r0w = rmst_pkg::CFG_W'(in_data_i.row_start);
  assign c0w = rmst_pkg::CFG_W'(in_data_i.col_start);
  assign r1w = rmst_pkg::CFG_W'(in_data_i.row_end);
  assign c1w = rmst_pkg::CFG_W'(in_data_i.col_end);
  assign hgt = r1w - r0w + rmst_pkg::CFG_W'(1);
  assign wid = c1w - c0w + rmst_pkg::CFG_W'(1);

  always_comb begin
    cmd_d       = cmd_q;
    cmd_d.r0    = in_data_i.row_start;
    cmd_d.c0    = in_data_i.col_start;
    cmd_d.value = in_data_i.cell_value;
    cmd_d.t1    = rmst_pkg::floor_log2(hgt);
    cmd_d.t2    = rmst_pkg::floor_log2(wid);
    cmd_d.rb    = rmst_pkg::POS_W'(r1w + rmst_pkg::CFG_W'(1)
                  - (rmst_pkg::CFG_W'(1) << cmd_d.t1));
    cmd_d.cb    = rmst_pkg::POS_W'(c1w + rmst_pkg::CFG_W'(1)
                  - (rmst_pkg::CFG_W'(1) << cmd_d.t2));
    unique case (in_data_i.kind)
      rmst_pkg::KIND_LOAD: begin
        cmd_d.op = (r0w >= rows_i || c0w >= cols_i) ? rmst_pkg::OP_BAD : rmst_pkg::OP_LOAD;
      end
      rmst_pkg::KIND_BUILD: cmd_d.op = rmst_pkg::OP_BUILD;
      rmst_pkg::KIND_QUERY: begin
        if (r0w > r1w || c0w > c1w || r1w >= rows_i || c1w >= cols_i) begin
          cmd_d.op = rmst_pkg::OP_BAD;
        end else begin
          cmd_d.op = rmst_pkg::OP_QUERY;
        end
      end
      default: cmd_d.op = rmst_pkg::OP_BAD;
    endcase
  end

  always_comb begin
    v_d = v_q;
    if (take) v_d = 1'b1;
    else if (cmd_ready_i) v_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) cmd_q <= cmd_d;
  end

endmodule

// ----- sv/rmst_fifo.sv -----
module rmst_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  rmst_pkg::cmd_t push_data_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output rmst_pkg::cmd_t pop_data_o
);

  rmst_pkg::cmd_t ent_q [2];
  logic           wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = ent_q[rptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wptr_d = wptr_q ^ push;
    rptr_d = rptr_q ^ pop;
    cnt_d  = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) ent_q[wptr_q] <= push_data_i;
  end

endmodule

// ----- sv/rmst_back.sv -----
module rmst_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rmst_pkg::cfg_t     cfg_i,
  input  logic               cmd_valid_i,
  output logic               cmd_ready_o,
  input  rmst_pkg::cmd_t     cmd_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rmst_pkg::out_item_t out_data_o
);

  localparam int VW = rmst_pkg::VALUE_WIDTH;
  localparam int PW = rmst_pkg::PW_W;

  rmst_pkg::bk_state_e state_q, state_d;
  rmst_pkg::cmd_t      cmd_q, cmd_d;
  logic                built_q, built_d;
  logic [rmst_pkg::LCNT_W-1:0] i_q, i_d, j_q, j_d;
  logic [rmst_pkg::POS_W-1:0]  r_q, r_d, c_q, c_d;
  logic signed [VW-1:0]        a_q, a_d, acc_q, acc_d;
  logic                        out_v_q, out_v_d;
  rmst_pkg::out_item_t         out_q, out_d;

  logic [VW-1:0]               mem [rmst_pkg::DEPTH];
  logic signed [VW-1:0]        rdata_q;
  logic                        mem_we;
  logic [rmst_pkg::ADDR_W-1:0] waddr, raddr;
  logic signed [VW-1:0]        wdata;

  logic                        out_free, pop;
  logic [PW-1:0]               pow_i, pow_j;
  logic                        i_done, j_skip, c_more, r_more, res_v;
  logic [rmst_pkg::LVL_W-1:0]  li, lj, li_m1, lj_m1;
  logic [rmst_pkg::POS_W-1:0]  half_i, half_j;
  rmst_pkg::out_item_t         res;

  assign out_free    = !out_v_q || out_ready_i;
  assign cmd_ready_o = (state_q == rmst_pkg::BK_IDLE) && out_free;
  assign pop         = cmd_valid_i && cmd_ready_o;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  assign pow_i  = PW'(1) << i_q;
  assign pow_j  = PW'(1) << j_q;
  assign i_done = (i_q == rmst_pkg::LCNT_W'(rmst_pkg::LEVELS)) || (pow_i > PW'(cfg_i.rows));
  assign j_skip = (j_q == rmst_pkg::LCNT_W'(rmst_pkg::LEVELS)) || (pow_j > PW'(cfg_i.cols));
  assign c_more = (PW'(c_q) + PW'(1) + pow_j) <= PW'(cfg_i.cols);
  assign r_more = (PW'(r_q) + PW'(1) + pow_i) <= PW'(cfg_i.rows);
  assign li     = rmst_pkg::LVL_W'(i_q);
  assign lj     = rmst_pkg::LVL_W'(j_q);
  assign li_m1  = rmst_pkg::LVL_W'(i_q - rmst_pkg::LCNT_W'(1));
  assign lj_m1  = rmst_pkg::LVL_W'(j_q - rmst_pkg::LCNT_W'(1));
  assign half_i = rmst_pkg::POS_W'(PW'(1) << li_m1);
  assign half_j = rmst_pkg::POS_W'(PW'(1) << lj_m1);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rmst_pkg::BK_IDLE: begin
        if (pop) begin
          if (cmd_i.op == rmst_pkg::OP_BUILD) state_d = rmst_pkg::BK_LVL;
          else if (cmd_i.op == rmst_pkg::OP_QUERY && built_q) state_d = rmst_pkg::BK_Q0;
        end
      end
      rmst_pkg::BK_LVL: begin
        if (i_done) state_d = rmst_pkg::BK_IDLE;
        else if (!j_skip && !(i_q == '0 && j_q == '0)) state_d = rmst_pkg::BK_RDA;
      end
      rmst_pkg::BK_RDA: state_d = rmst_pkg::BK_RDB;
      rmst_pkg::BK_RDB: state_d = rmst_pkg::BK_WR;
      rmst_pkg::BK_WR:  state_d = (c_more || r_more) ? rmst_pkg::BK_RDA : rmst_pkg::BK_LVL;
      rmst_pkg::BK_Q0:  state_d = rmst_pkg::BK_Q1;
      rmst_pkg::BK_Q1:  state_d = rmst_pkg::BK_Q2;
      rmst_pkg::BK_Q2:  state_d = rmst_pkg::BK_Q3;
      rmst_pkg::BK_Q3:  state_d = rmst_pkg::BK_QL;
      rmst_pkg::BK_QL:  state_d = rmst_pkg::BK_IDLE;
      default:          state_d = rmst_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_d   = cmd_q;
    built_d = built_q;
    i_d     = i_q;
    j_d     = j_q;
    r_d     = r_q;
    c_d     = c_q;
    a_d     = a_q;
    acc_d   = acc_q;
    mem_we  = 1'b0;
    waddr   = '0;
    wdata   = cmd_q.value;
    raddr   = '0;
    res_v   = 1'b0;
    res     = '0;
    if (cfg_i.wr) built_d = 1'b0;
    unique case (state_q)
      rmst_pkg::BK_IDLE: begin
        if (pop) begin
          cmd_d = cmd_i;
          case (cmd_i.op)
            rmst_pkg::OP_LOAD: begin
              mem_we  = 1'b1;
              waddr   = rmst_pkg::tab_addr(cmd_i.r0, cmd_i.c0, '0, '0);
              wdata   = cmd_i.value;
              built_d = 1'b0;
              res_v   = 1'b1;
            end
            rmst_pkg::OP_BUILD: begin
              i_d = '0;
              j_d = '0;
            end
            rmst_pkg::OP_QUERY: begin
              if (!built_q) begin
                res_v      = 1'b1;
                res.status = rmst_pkg::ST_UNBUILT;
              end
            end
            default: begin
              res_v      = 1'b1;
              res.status = rmst_pkg::ST_BAD;
            end
          endcase
        end
      end
      rmst_pkg::BK_LVL: begin
        if (i_done) begin
          built_d = 1'b1;
          res_v   = 1'b1;
        end else if (j_skip) begin
          i_d = i_q + rmst_pkg::LCNT_W'(1);
          j_d = '0;
        end else if (i_q == '0 && j_q == '0) begin
          j_d = rmst_pkg::LCNT_W'(1);
        end else begin
          r_d = '0;
          c_d = '0;
        end
      end
      rmst_pkg::BK_RDA: begin
        raddr = (i_q != '0) ? rmst_pkg::tab_addr(r_q, c_q, li_m1, lj)
                            : rmst_pkg::tab_addr(r_q, c_q, li, lj_m1);
      end
      rmst_pkg::BK_RDB: begin
        raddr = (i_q != '0) ? rmst_pkg::tab_addr(r_q + half_i, c_q, li_m1, lj)
                            : rmst_pkg::tab_addr(r_q, c_q + half_j, li, lj_m1);
        a_d   = rdata_q;
      end
      rmst_pkg::BK_WR: begin
        mem_we = 1'b1;
        waddr  = rmst_pkg::tab_addr(r_q, c_q, li, lj);
        wdata  = rmst_pkg::vmax(a_q, rdata_q);
        if (c_more) begin
          c_d = c_q + rmst_pkg::POS_W'(1);
        end else begin
          c_d = '0;
          if (r_more) r_d = r_q + rmst_pkg::POS_W'(1);
          else j_d = j_q + rmst_pkg::LCNT_W'(1);
        end
      end
      rmst_pkg::BK_Q0: raddr = rmst_pkg::tab_addr(cmd_q.r0, cmd_q.c0, cmd_q.t1, cmd_q.t2);
      rmst_pkg::BK_Q1: begin
        raddr = rmst_pkg::tab_addr(cmd_q.rb, cmd_q.c0, cmd_q.t1, cmd_q.t2);
        acc_d = rdata_q;
      end
      rmst_pkg::BK_Q2: begin
        raddr = rmst_pkg::tab_addr(cmd_q.r0, cmd_q.cb, cmd_q.t1, cmd_q.t2);
        acc_d = rmst_pkg::vmax(acc_q, rdata_q);
      end
      rmst_pkg::BK_Q3: begin
        raddr = rmst_pkg::tab_addr(cmd_q.rb, cmd_q.cb, cmd_q.t1, cmd_q.t2);
        acc_d = rmst_pkg::vmax(acc_q, rdata_q);
      end
      rmst_pkg::BK_QL: begin
        res_v         = 1'b1;
        res.max_value = rmst_pkg::vmax(acc_q, rdata_q);
      end
      default: ;
    endcase
  end

  // output register is always free when a result is produced
  always_comb begin
    out_v_d = out_v_q;
    out_d   = out_q;
    if (res_v) begin
      out_v_d = 1'b1;
      out_d   = res;
    end else if (out_ready_i) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rmst_pkg::BK_IDLE;
      built_q <= 1'b0;
      out_v_q <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
      r_q     <= '0;
      c_q     <= '0;
    end else begin
      state_q <= state_d;
      built_q <= built_d;
      out_v_q <= out_v_d;
      i_q     <= i_d;
      j_q     <= j_d;
      r_q     <= r_d;
      c_q     <= c_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    a_q   <= a_d;
    acc_q <= acc_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

endmodule

// ----- sv/range_max_2d_sparse_table.sv -----
// Rectangle range-maximum engine over a grid of signed 16-bit values.
// Input channel (in_valid_i/in_ready_o/in_data_i) takes load, build and query
// items; output channel (out_valid_o/out_ready_i/out_data_o) returns exactly
// one result item per input item, in order.
// APB port: rows_in_use at 0x0, cols_in_use at 0x4; writes saturate to
// 1..32 and mark the table unbuilt. Write only while the block is idle.
// Load, bad item and unbuilt query are answered from the idle state of the
// execution unit; a query makes four reads from the single read port of the
// table RAM and holds the execution unit until its result is out. One load or
// rejected item per cycle while the receiver takes every result. A build
// makes two reads and a write per table entry, over every level pair with
// a block size inside the grid.
// A two-entry queue sits between the classifier and the execution unit;
// with the classifier's register, up to three items are taken during a build.
// Reset clears the built flag and the handshake state, sets both sizes
// to 32; the table RAM is not cleared and reads undefined until loaded.
// If the receiver stalls, the result is held and the execution unit waits,
// the queue fills and in_ready_o drops.
module range_max_2d_sparse_table (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rmst_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rmst_pkg::out_item_t out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [rmst_pkg::CFG_W-1:0] rows_q, rows_d, cols_q, cols_d;
  logic                       wr;
  rmst_pkg::reg_e             ridx;
  rmst_pkg::cfg_t             cfg;
  logic                       fq_valid, fq_ready, bq_valid, bq_ready;
  rmst_pkg::cmd_t             fq_cmd, bq_cmd;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign ridx   = rmst_pkg::reg_e'(paddr[2]);

  always_comb begin
    rows_d = rows_q;
    cols_d = cols_q;
    if (wr) begin
      unique case (ridx)
        rmst_pkg::REG_ROWS: rows_d = rmst_pkg::sat_cfg(pwdata[rmst_pkg::CFG_W-1:0],
                                       rmst_pkg::CFG_W'(rmst_pkg::MAX_ROWS));
        rmst_pkg::REG_COLS: cols_d = rmst_pkg::sat_cfg(pwdata[rmst_pkg::CFG_W-1:0],
                                       rmst_pkg::CFG_W'(rmst_pkg::MAX_COLS));
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      rmst_pkg::REG_ROWS: prdata = 32'(rows_q);
      rmst_pkg::REG_COLS: prdata = 32'(cols_q);
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= rmst_pkg::CFG_W'(rmst_pkg::MAX_ROWS);
      cols_q <= rmst_pkg::CFG_W'(rmst_pkg::MAX_COLS);
    end else begin
      rows_q <= rows_d;
      cols_q <= cols_d;
    end
  end

  assign cfg.rows = rows_q;
  assign cfg.cols = cols_q;
  assign cfg.wr   = wr;

  rmst_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .rows_i      (rows_q),
    .cols_i      (cols_q),
    .cmd_valid_o (fq_valid),
    .cmd_ready_i (fq_ready),
    .cmd_o       (fq_cmd)
  );

  rmst_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_data_i  (fq_cmd),
    .pop_valid_o  (bq_valid),
    .pop_ready_i  (bq_ready),
    .pop_data_o   (bq_cmd)
  );

  rmst_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_valid_i (bq_valid),
    .cmd_ready_o (bq_ready),
    .cmd_i       (bq_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- sv/rmst_checker.sv -----
`include "assert_macros.svh"

module rmst_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input rmst_pkg::in_item_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input rmst_pkg::out_item_t out_data_o,
  input logic                psel,
  input logic                penable,
  input logic                pwrite,
  input logic [31:0]         prdata
);

  logic in_wait, out_wait, out_err, out_spare, cfg_wr;

  assign in_wait   = in_valid_i && !in_ready_o;
  assign out_wait  = out_valid_o && !out_ready_i;
  assign out_err   = out_valid_o && (out_data_o.status != rmst_pkg::ST_OK);
  assign out_spare = out_err && (out_data_o.status != rmst_pkg::ST_BAD)
                     && (out_data_o.status != rmst_pkg::ST_UNBUILT);
  assign cfg_wr    = psel && penable && pwrite;

  `RMST_ASSERT(a_in_hold, clk_i, rst_ni, in_wait |=> in_valid_i && $stable(in_data_i))

  `RMST_ASSERT(a_out_hold, clk_i, rst_ni, out_wait |=> out_valid_o && $stable(out_data_o))

  `RMST_ASSERT(a_zero_on_err, clk_i, rst_ni, out_err |-> out_data_o.max_value == '0)

  `RMST_NEVER(a_no_spare_status, clk_i, rst_ni, out_spare)

  `RMST_ASSERT(a_cfg_clamped, clk_i, rst_ni, cfg_wr |=> prdata != '0)

endmodule

bind range_max_2d_sparse_table rmst_checker u_rmst_checker (.*);

// ----- tb/rmst_checker.sv -----
`timescale 1ns / 1ps

module rmst_tb_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  rmst_pkg::in_item_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  rmst_pkg::out_item_t out_data_i,
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic [2:0]          paddr_i,
  input  logic [31:0]         pwdata_i,
  output int                  fail_cnt_o,
  output int                  pending_o
);

  logic signed [15:0]  blk_max [32][32][6][6];
  logic                built_q;
  int unsigned         grid_rows, grid_cols;
  rmst_pkg::out_item_t expected_q [$];

  assign pending_o = expected_q.size();

  function automatic int unsigned clamp_size(logic [31:0] v);
    int unsigned x;
    x = 32'(v[5:0]);
    if (x < 1) x = 1;
    if (x > 32) x = 32;
    return x;
  endfunction

  function automatic int unsigned lg2(int unsigned v);
    int unsigned t;
    t = 0;
    while ((v >> 1) != 0) begin
      v = v >> 1;
      t++;
    end
    if (t > 5) t = 5;
    return t;
  endfunction

  function automatic logic signed [15:0] bigger(logic signed [15:0] a, logic signed [15:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic void rebuild_levels();
    logic signed [15:0] m;
    for (int i = 0; i < 6 && (1 << i) <= grid_rows; i++)
      for (int j = 0; j < 6 && (1 << j) <= grid_cols; j++) begin
        if (i == 0 && j == 0) continue;
        for (int r = 0; r + (1 << i) <= grid_rows; r++)
          for (int c = 0; c + (1 << j) <= grid_cols; c++) begin
            m = blk_max[r][c][0][0];
            if (i != 0) begin
              m = bigger(m, blk_max[r][c][i-1][j]);
              m = bigger(m, blk_max[r + (1 << (i-1))][c][i-1][j]);
            end
            if (j != 0) begin
              m = bigger(m, blk_max[r][c][i][j-1]);
              m = bigger(m, blk_max[r][c + (1 << (j-1))][i][j-1]);
            end
            blk_max[r][c][i][j] = m;
          end
      end
    built_q = 1'b1;
  endfunction

  function automatic rmst_pkg::out_item_t predict_rect_max(rmst_pkg::in_item_t it);
    rmst_pkg::out_item_t o;
    int unsigned         r0, c0, r1, c1, t1, t2, rb, cb;
    o = '0;
    r0 = 32'(it.row_start);
    c0 = 32'(it.col_start);
    r1 = 32'(it.row_end);
    c1 = 32'(it.col_end);
    case (it.kind)
      rmst_pkg::KIND_LOAD: begin
        if (r0 >= grid_rows || c0 >= grid_cols) o.status = rmst_pkg::ST_BAD;
        else begin
          blk_max[r0][c0][0][0] = it.cell_value;
          built_q = 1'b0;
        end
      end
      rmst_pkg::KIND_BUILD: rebuild_levels();
      rmst_pkg::KIND_QUERY: begin
        if (r0 > r1 || c0 > c1 || r1 >= grid_rows || c1 >= grid_cols) begin
          o.status = rmst_pkg::ST_BAD;
        end else if (!built_q) begin
          o.status = rmst_pkg::ST_UNBUILT;
        end else begin
          t1 = lg2(r1 - r0 + 1);
          t2 = lg2(c1 - c0 + 1);
          rb = r1 + 1 - (1 << t1);
          cb = c1 + 1 - (1 << t2);
          o.max_value = bigger(bigger(blk_max[r0][c0][t1][t2], blk_max[rb][c0][t1][t2]),
                               bigger(blk_max[r0][cb][t1][t2], blk_max[rb][cb][t1][t2]));
        end
      end
      default: o.status = rmst_pkg::ST_BAD;
    endcase
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rmst_pkg::out_item_t e;
    if (!rst_ni) begin
      built_q    = 1'b0;
      grid_rows  = 32;
      grid_cols  = 32;
      fail_cnt_o = 0;
      expected_q.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i) begin
        if (paddr_i[2] == rmst_pkg::REG_ROWS) grid_rows = clamp_size(pwdata_i);
        else grid_cols = clamp_size(pwdata_i);
        built_q = 1'b0;
      end
      if (in_valid_i && in_ready_i) expected_q.push_back(predict_rect_max(in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("result with nothing expected: max_value %0d status %0d",
                 out_data_i.max_value, out_data_i.status);
          fail_cnt_o = fail_cnt_o + 1;
        end else begin
          e = expected_q.pop_front();
          if (e.max_value !== out_data_i.max_value) begin
            $error("max_value expected %0d actual %0d", e.max_value, out_data_i.max_value);
            fail_cnt_o = fail_cnt_o + 1;
          end
          if (e.status !== out_data_i.status) begin
            $error("status expected %0d actual %0d", e.status, out_data_i.status);
            fail_cnt_o = fail_cnt_o + 1;
          end
        end
      end
    end
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  localparam int WATCHDOG = 200000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid, in_ready, out_valid, out_ready;
  rmst_pkg::in_item_t  in_data;
  rmst_pkg::out_item_t out_data;
  logic      psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  int        fail_cnt, pending;
  int        idle_cycles;
  bit        calm;
  bit        hold_off;
  int unsigned rows_now, cols_now;
  bit        loaded [32][32];

  always #5 clk_i = ~clk_i;

  range_max_2d_sparse_table i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  rmst_tb_checker i_checker (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_data_i(out_data),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  // watchdog on accepted items
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_ni) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver side
  initial begin
    out_ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) out_ready <= 1'b0;
      else if (!calm && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk_i);
        out_ready <= 1'b1;
      end else out_ready <= 1'b1;
    end
  end

  task automatic send_item(rmst_pkg::in_item_t it);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    in_data  = it;
    in_valid = 1'b1;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    @(negedge clk_i);
    in_valid = 1'b0;
  endtask

  task automatic write_reg(rmst_pkg::reg_e idx, logic [31:0] v);
    psel = 1'b1; pwrite = 1'b1; paddr = {idx, 2'b00}; pwdata = v;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    if (idx == rmst_pkg::REG_ROWS) rows_now = (v[5:0] == 0) ? 1 : (v[5:0] > 32 ? 32 : v[5:0]);
    else cols_now = (v[5:0] == 0) ? 1 : (v[5:0] > 32 ? 32 : v[5:0]);
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic load_cell(int r, int c, logic signed [15:0] v);
    rmst_pkg::in_item_t it;
    it = '0;
    it.kind = rmst_pkg::KIND_LOAD; it.row_start = 5'(r); it.col_start = 5'(c);
    it.cell_value = v;
    if (r < rows_now && c < cols_now) loaded[r][c] = 1'b1;
    send_item(it);
  endtask

  task automatic fill_grid(bit rand_vals);
    for (int r = 0; r < rows_now; r++)
      for (int c = 0; c < cols_now; c++)
        load_cell(r, c, rand_vals ? 16'($urandom) : 16'((r * 37 + c * 11) % 200 - 100));
  endtask

  function automatic bit grid_ready();
    for (int r = 0; r < rows_now; r++)
      for (int c = 0; c < cols_now; c++)
        if (!loaded[r][c]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic send_build();
    rmst_pkg::in_item_t it;
    it = rmst_pkg::in_item_t'($urandom);
    it.kind = rmst_pkg::KIND_BUILD;
    if (grid_ready()) send_item(it);
  endtask

  task automatic send_query(int r0, int c0, int r1, int c1);
    rmst_pkg::in_item_t it;
    it = rmst_pkg::in_item_t'({$urandom, $urandom});
    it.kind = rmst_pkg::KIND_QUERY;
    it.row_start = 5'(r0); it.col_start = 5'(c0); it.row_end = 5'(r1); it.col_end = 5'(c1);
    send_item(it);
  endtask

  task automatic random_query();
    int r0, r1, c0, c1;
    if ($urandom_range(0, 9) == 0) begin
      send_query($urandom_range(0, 31), $urandom_range(0, 31),
                 $urandom_range(0, 31), $urandom_range(0, 31));
    end else begin
      r0 = $urandom_range(0, rows_now - 1); r1 = $urandom_range(r0, rows_now - 1);
      c0 = $urandom_range(0, cols_now - 1); c1 = $urandom_range(c0, cols_now - 1);
      send_query(r0, c0, r1, c1);
    end
  endtask

  initial begin
    rmst_pkg::in_item_t it;
    in_valid = 1'b0; in_data = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    calm = 1'b0; hold_off = 1'b0;
    rows_now = 32; cols_now = 32;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: tiny grid and extreme values
    write_reg(rmst_pkg::REG_ROWS, 32'd0);
    write_reg(rmst_pkg::REG_COLS, 32'd2);
    send_query(0, 0, 0, 0);
    load_cell(0, 0, 16'sh7fff);
    load_cell(0, 1, 16'sh8000);
    load_cell(1, 0, 16'sd5);
    send_query(0, 0, 0, 1);
    send_build();
    send_query(0, 0, 0, 1);
    send_query(0, 1, 0, 1);
    send_query(0, 1, 0, 0);
    send_query(0, 0, 1, 0);
    send_query(31, 31, 31, 31);
    it = '1; send_item(it);
    it = '0; it.kind = rmst_pkg::KIND_LOAD; it.row_start = 5'd5; send_item(it);
    drain();
    write_reg(rmst_pkg::REG_ROWS, 32'd63);
    write_reg(rmst_pkg::REG_COLS, 32'hffff_ffe0);
    fill_grid(1'b0);
    send_query(0, 0, 31, 31);
    send_build();
    send_query(0, 0, 31, 31);
    send_query(3, 7, 29, 18);
    send_query(31, 0, 31, 31);
    drain();

    // random phases over several grid shapes
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          write_reg(rmst_pkg::REG_ROWS, 32'd1); write_reg(rmst_pkg::REG_COLS, 32'd1);
        end
        1: begin
          write_reg(rmst_pkg::REG_ROWS, 32'd32); write_reg(rmst_pkg::REG_COLS, 32'd3);
        end
        7: begin
          write_reg(rmst_pkg::REG_ROWS, 32'd5); write_reg(rmst_pkg::REG_COLS, 32'd7);
        end
        default: begin
          write_reg(rmst_pkg::REG_ROWS, $urandom_range(1, 12));
          write_reg(rmst_pkg::REG_COLS, $urandom_range(1, 12));
        end
      endcase
      if (ph == 7) calm = 1'b1;
      fill_grid(1'b1);
      send_build();
      for (int k = 0; k < 60; k++) begin
        if (ph == 3 && k == 20) begin
          hold_off = 1'b1;
          fork
            begin repeat (300) @(negedge clk_i); hold_off = 1'b0; end
          join_none
        end
        case ($urandom_range(0, 19))
          0: begin
            load_cell($urandom_range(0, 31), $urandom_range(0, 31), 16'($urandom));
          end
          1: send_build();
          2: begin
            it = rmst_pkg::in_item_t'({$urandom, $urandom});
            it.kind = 2'd3;
            send_item(it);
          end
          3: begin
            if (rows_now * cols_now <= 40) fill_grid(1'b1);
            load_cell($urandom_range(0, rows_now - 1), $urandom_range(0, cols_now - 1),
                      16'($urandom));
          end
          default: random_query();
        endcase
      end
      drain();
    end

    while (pending != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    if (fail_cnt == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
